// ===== rtl/acd_pkg.sv =====
package acd_pkg;

	localparam int ANGLE_W   = 16;
	localparam int TIME_W    = 32;
	localparam int THR_W     = 16;
	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [THR_W-1:0] THR_RESET = 16'd410;

	localparam logic [MODE_W-1:0] MODE_STAND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WALK  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ERROR_STAND = 1'b0,
		CFG_MAX_ERROR_WALK  = 1'b1
	} acd_cfg_idx_t;

	// per-item control shared by both arm sides
	typedef struct packed {
		logic clear;    // mode not allowed: drop sums
		logic cmd_wr;   // item taken into the command delay line
		logic err_wr;   // delay line full: error enters the window
		logic win_full; // window full before this item
		logic flag_en;  // window full after this item
	} acd_ctrl_t;

endpackage

// ===== rtl/acd_ring.sv =====
module acd_ring #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ahead at the address the next item needs; forward a write to the same entry
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/acd_side.sv =====
module acd_side #(
	parameter int CMD_DEPTH = 4,
	parameter int WIN_DEPTH = 16,
	parameter int CAW       = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
	parameter int EAW       = $clog2(WIN_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  acd_pkg::acd_ctrl_t                 ctrl,
	input  logic signed [acd_pkg::ANGLE_W-1:0] cmd,
	input  logic signed [acd_pkg::ANGLE_W-1:0] sensed,
	input  logic [acd_pkg::THR_W-1:0]          thr,
	input  logic [CAW-1:0]                     cptr,
	input  logic [CAW-1:0]                     crd_addr,
	input  logic [EAW-1:0]                     eptr,
	input  logic [EAW-1:0]                     erd_addr,
	output logic                               hit
);
	import acd_pkg::*;

	localparam int SUM_W = ANGLE_W + $clog2(WIN_DEPTH);

	logic [ANGLE_W-1:0] cmd_rd;
	logic [ANGLE_W-1:0] win_rd;
	logic [ANGLE_W-1:0] oldest;
	logic signed [ANGLE_W:0] diff;
	logic [ANGLE_W:0]   abs_diff;
	logic [ANGLE_W-1:0] err;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_new;
	logic [SUM_W-1:0]   sum_eff;
	logic [SUM_W-1:0]   lim;

	acd_ring #(.DEPTH(CMD_DEPTH), .WIDTH(ANGLE_W), .AW(CAW)) u_cmd (
		.clk     (clk),
		.wr_en   (ctrl.cmd_wr),
		.wr_addr (cptr),
		.wr_data (cmd),
		.rd_addr (crd_addr),
		.rd_data (cmd_rd)
	);

	acd_ring #(.DEPTH(WIN_DEPTH), .WIDTH(ANGLE_W), .AW(EAW)) u_win (
		.clk     (clk),
		.wr_en   (ctrl.err_wr),
		.wr_addr (eptr),
		.wr_data (err),
		.rd_addr (erd_addr),
		.rd_data (win_rd)
	);

	always_comb begin
		// a one-deep line hands the current command straight through
		oldest   = (CMD_DEPTH == 1) ? cmd : cmd_rd;
		diff     = $signed({oldest[ANGLE_W-1], oldest}) - $signed({sensed[ANGLE_W-1], sensed});
		abs_diff = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : diff;
		err      = abs_diff[ANGLE_W] ? {ANGLE_W{1'b1}} : abs_diff[ANGLE_W-1:0];
		sum_new  = sum_q - (ctrl.win_full ? SUM_W'(win_rd) : '0) + SUM_W'(err);
		sum_eff  = ctrl.err_wr ? sum_new : sum_q;
		lim      = SUM_W'(thr) * SUM_W'(WIN_DEPTH);
		hit      = ctrl.flag_en && (sum_eff > lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.err_wr) begin
			sum_q <= sum_new;
		end
	end

endmodule

// ===== rtl/arm_collision_detector.sv =====
// Channel  Dir  tdata                                        tuser
// s_*      in   cmd_l, cmd_r, sensed_l, sensed_r, frame_time  arm_mode_allowed, motion_mode
// m_*      out  hit_time                                     hit_left, hit_right
// cfg_*    in   write enable, register index, 16-bit data    -
//
// Throughput is one item per clock while the output is not stalled. An item
// waits in the input register and is evaluated on its way into the output
// register. Evaluation rests on the running window sums and on both rings
// reading ahead at the next item's slot.
// Reset clears fill counts, ring pointers, sums and handshake state; ring
// contents are left as they are. A stalled output holds the input register,
// and s_tready drops only while both stages are full and m_tready is low.
module arm_collision_detector #(
	parameter int COMMAND_DELAY_DEPTH = 4,
	parameter int ERROR_WINDOW_DEPTH  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] commanded_left, [31:16] commanded_right, [47:32] sensed_left,
	// [63:48] sensed_right, [95:64] frame_time
	input  logic [acd_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] arm_mode_allowed, [2:1] motion_mode
	input  logic [acd_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] hit_time
	output logic [acd_pkg::M_TDATA_W-1:0]    m_tdata,
	// [0] hit_left, [1] hit_right
	output logic [acd_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                             cfg_we,
	input  logic [acd_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [acd_pkg::THR_W-1:0]        cfg_data
);
	import acd_pkg::*;

	localparam int CAW = (COMMAND_DELAY_DEPTH > 1) ? $clog2(COMMAND_DELAY_DEPTH) : 1;
	localparam int EAW = $clog2(ERROR_WINDOW_DEPTH);
	localparam int CFW = $clog2(COMMAND_DELAY_DEPTH + 1);
	localparam int EFW = $clog2(ERROR_WINDOW_DEPTH + 1);
	localparam logic [CAW-1:0] C_LAST  = CAW'(COMMAND_DELAY_DEPTH - 1);
	localparam logic [EAW-1:0] E_LAST  = EAW'(ERROR_WINDOW_DEPTH - 1);
	localparam logic [CFW-1:0] C_FULL  = CFW'(COMMAND_DELAY_DEPTH);
	localparam logic [CFW-1:0] C_ALMOST = CFW'(COMMAND_DELAY_DEPTH - 1);
	localparam logic [EFW-1:0] E_FULL  = EFW'(ERROR_WINDOW_DEPTH);
	localparam logic [EFW-1:0] E_ALMOST = EFW'(ERROR_WINDOW_DEPTH - 1);

	// thresholds
	logic [THR_W-1:0] thr_stand_q;
	logic [THR_W-1:0] thr_walk_q;

	// input register
	logic                      valid_s1;
	logic                      allowed_s1;
	logic [MODE_W-1:0]         mode_s1;
	logic signed [ANGLE_W-1:0] cmd_l_s1;
	logic signed [ANGLE_W-1:0] cmd_r_s1;
	logic signed [ANGLE_W-1:0] sen_l_s1;
	logic signed [ANGLE_W-1:0] sen_r_s1;
	logic [TIME_W-1:0]         time_s1;

	// ring and fill state
	logic [CAW-1:0] cptr_q, cptr_n, crd_addr;
	logic [EAW-1:0] eptr_q, eptr_n;
	logic [CFW-1:0] cfill_q;
	logic [EFW-1:0] efill_q;

	// result register
	logic              out_valid_q;
	logic              hit_l_q;
	logic              hit_r_q;
	logic [TIME_W-1:0] hit_time_q;

	logic       adv, proc, mode_ok;
	logic       hit_l, hit_r;
	logic [THR_W-1:0] thr;
	acd_ctrl_t  ctrl;

	function automatic logic [CAW-1:0] cinc(input logic [CAW-1:0] p);
		return (p == C_LAST) ? '0 : CAW'(p + 1'b1);
	endfunction

	function automatic logic [EAW-1:0] einc(input logic [EAW-1:0] p);
		return (p == E_LAST) ? '0 : EAW'(p + 1'b1);
	endfunction

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign proc     = valid_s1 && adv;
	assign mode_ok  = allowed_s1 && ((mode_s1 == MODE_STAND) || (mode_s1 == MODE_WALK));
	assign thr      = (mode_s1 == MODE_WALK) ? thr_walk_q : thr_stand_q;

	always_comb begin
		ctrl.clear    = proc && !mode_ok;
		ctrl.cmd_wr   = proc && mode_ok;
		// the line counts as full once this item has entered it
		ctrl.err_wr   = ctrl.cmd_wr && (cfill_q >= C_ALMOST);
		ctrl.win_full = (efill_q == E_FULL);
		ctrl.flag_en  = ctrl.cmd_wr &&
			(ctrl.win_full || (ctrl.err_wr && (efill_q == E_ALMOST)));
		cptr_n = ctrl.clear ? '0 : (ctrl.cmd_wr ? cinc(cptr_q) : cptr_q);
		eptr_n = ctrl.clear ? '0 : (ctrl.err_wr ? einc(eptr_q) : eptr_q);
		// oldest command for the next item sits one past the write slot
		crd_addr = cinc(cptr_n);
	end

	acd_side #(
		.CMD_DEPTH (COMMAND_DELAY_DEPTH),
		.WIN_DEPTH (ERROR_WINDOW_DEPTH),
		.CAW       (CAW),
		.EAW       (EAW)
	) u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cmd      (cmd_l_s1),
		.sensed   (sen_l_s1),
		.thr      (thr),
		.cptr     (cptr_q),
		.crd_addr (crd_addr),
		.eptr     (eptr_q),
		.erd_addr (eptr_n),
		.hit      (hit_l)
	);

	acd_side #(
		.CMD_DEPTH (COMMAND_DELAY_DEPTH),
		.WIN_DEPTH (ERROR_WINDOW_DEPTH),
		.CAW       (CAW),
		.EAW       (EAW)
	) u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cmd      (cmd_r_s1),
		.sensed   (sen_r_s1),
		.thr      (thr),
		.cptr     (cptr_q),
		.crd_addr (crd_addr),
		.eptr     (eptr_q),
		.erd_addr (eptr_n),
		.hit      (hit_r)
	);

	// configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_stand_q <= THR_RESET;
			thr_walk_q  <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAX_ERROR_STAND: thr_stand_q <= cfg_data;
				CFG_MAX_ERROR_WALK:  thr_walk_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			allowed_s1 <= s_tuser[0];
			mode_s1    <= s_tuser[2:1];
			cmd_l_s1   <= s_tdata[15:0];
			cmd_r_s1   <= s_tdata[31:16];
			sen_l_s1   <= s_tdata[47:32];
			sen_r_s1   <= s_tdata[63:48];
			time_s1    <= s_tdata[95:64];
		end
	end

	// pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cptr_q  <= '0;
			eptr_q  <= '0;
			cfill_q <= '0;
			efill_q <= '0;
		end else begin
			cptr_q <= cptr_n;
			eptr_q <= eptr_n;
			if (ctrl.clear) begin
				cfill_q <= '0;
				efill_q <= '0;
			end else begin
				if (ctrl.cmd_wr && (cfill_q != C_FULL)) begin
					cfill_q <= CFW'(cfill_q + 1'b1);
				end
				if (ctrl.err_wr && !ctrl.win_full) begin
					efill_q <= EFW'(efill_q + 1'b1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			hit_l_q    <= hit_l;
			hit_r_q    <= hit_r;
			hit_time_q <= (hit_l || hit_r) ? time_s1 : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = hit_time_q;
	assign m_tuser  = {hit_r_q, hit_l_q};

endmodule

// ===== rtl/acd_checker.sv =====
module acd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [acd_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [acd_pkg::M_TUSER_W-1:0] m_tuser
);
	import acd_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// hit time is zero unless some side is flagged
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == '0) |-> (m_tdata == '0))
		else $error("hit time without a hit");

	// input side is held off only by a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

bind arm_collision_detector acd_checker u_acd_checker (.*);
